FILE: rtl/vector_arithmetic_unit_assert.svh
// assertion macros for the vector arithmetic unit
// included by vector_arithmetic_unit.sv, no other dependencies
`ifndef VECTOR_ARITHMETIC_UNIT_ASSERT_SVH
`define VECTOR_ARITHMETIC_UNIT_ASSERT_SVH
// antecedent implies consequent in the same cycle
`define VAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vau assertion failed");
// antecedent implies consequent in the next cycle
`define VAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vau assertion failed");
`endif

FILE: rtl/vau_pkg.sv
// shared types, constants and helper function of the vector arithmetic unit
// no dependencies
`default_nettype none
package vau_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_DIM    = 4;
    localparam int DIM_W      = 3;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int WIDE_W     = PROD_W + 4;
    localparam int SQ_STEPS   = DATA_W;
    localparam int LEN_W      = DATA_W + 1;
    localparam int NUM_W      = DATA_W + FRAC_BITS;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int NRM_W      = QUO_W + 1;
    localparam int NPROD_W    = 2 * NRM_W;
    localparam int LANES      = 2 * MAX_DIM;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int FIFO_DEPTH = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = 3'd3;
    localparam logic [DIM_W-1:0] DIM_MIN   = 3'd2;
    localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);

    localparam logic [PADDR_W-3:0] REG_DIM = '0;

    localparam logic signed [WIDE_W-1:0] SAT_HI =
        {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_LO =
        {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_NEG   = 3'd2,
        OP_SCALE = 3'd3,
        OP_DOT   = 3'd4,
        OP_MAG   = 3'd5,
        OP_NORM  = 3'd6,
        OP_COS   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef logic signed [DATA_W-1:0]  word_t;
    typedef logic signed [DATA_W:0]    lin_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [NRM_W-1:0]   nrm_t;
    typedef logic signed [NPROD_W-1:0] nprod_t;
    typedef logic [DATA_W-1:0]         mag_t;
    typedef word_t [MAX_DIM-1:0]       vec_t;

    // payload that travels through the square root pipeline
    typedef struct packed {
        op_t                      op;
        logic [DIM_W-1:0]         dim;
        vec_t                     vec;
        word_t                    scal;
        logic                     sat;
        mag_t [MAX_DIM-1:0]       lmag;
        mag_t [MAX_DIM-1:0]       rmag;
        logic [MAX_DIM-1:0]       lneg;
        logic [MAX_DIM-1:0]       rneg;
        logic                     lovf;
        logic                     rovf;
    } sq_side_t;

    // payload that travels through the divider pipeline
    typedef struct packed {
        op_t                      op;
        logic [DIM_W-1:0]         dim;
        vec_t                     vec;
        word_t                    scal;
        logic                     sat;
        logic [MAX_DIM-1:0]       lneg;
        logic [MAX_DIM-1:0]       rneg;
        logic                     lzero;
        logic                     rzero;
    } div_side_t;

    typedef struct packed {
        vec_t    vec;
        word_t   scal;
        status_t status;
    } res_t;

    // returns {clamped flag, clamped value}
    function automatic logic [DATA_W:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic [DATA_W:0] r;
        if (v > SAT_HI)
            r = {1'b1, SAT_HI[DATA_W-1:0]};
        else if (v < SAT_LO)
            r = {1'b1, SAT_LO[DATA_W-1:0]};
        else
            r = {1'b0, v[DATA_W-1:0]};
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/vau_in_if.sv
// operand channel of the vector arithmetic unit: valid/ready plus one item
// depends on vau_pkg
`default_nettype none
interface vau_in_if
    import vau_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [2:0]          operation;
    logic [DATA_W-1:0]   left_x;
    logic [DATA_W-1:0]   left_y;
    logic [DATA_W-1:0]   left_z;
    logic [DATA_W-1:0]   left_w;
    logic [DATA_W-1:0]   right_x;
    logic [DATA_W-1:0]   right_y;
    logic [DATA_W-1:0]   right_z;
    logic [DATA_W-1:0]   right_w;
    logic [DATA_W-1:0]   scale_factor;

    modport source (
        output valid, operation, left_x, left_y, left_z, left_w,
               right_x, right_y, right_z, right_w, scale_factor,
        input  ready
    );
    modport sink (
        input  valid, operation, left_x, left_y, left_z, left_w,
               right_x, right_y, right_z, right_w, scale_factor,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/vau_out_if.sv
// result channel of the vector arithmetic unit: valid/ready plus one result
// depends on vau_pkg
`default_nettype none
interface vau_out_if
    import vau_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   out_x;
    logic [DATA_W-1:0]   out_y;
    logic [DATA_W-1:0]   out_z;
    logic [DATA_W-1:0]   out_w;
    logic [DATA_W-1:0]   scalar_out;
    logic [1:0]          status;

    modport source (
        output valid, out_x, out_y, out_z, out_w, scalar_out, status,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, out_w, scalar_out, status,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/vector_arithmetic_unit.sv
// vector arithmetic unit top level: operand stages, square root, divider, output queue
// depends on vau_pkg, vau_in_if, vau_out_if, vau_apb_regs, vau_sqrt_pipe, vau_div_pipe
//
// Usage: items arrive on the operand channel (valid/ready); one result per item leaves
// on the result channel (valid/ready), in order. The user must write the dimension
// register (2..4, values outside clamp) via APB only while the unit is idle; unenforced.
// Path: an item passes through three operand stages (capture, 32x32 products, sums
// and rounding), 32 square root stages, one length rounding stage, 17 divider
// stages, one normalized product stage, then the output queue. Every operation takes
// the same path. Throughput: one item per cycle while the output queue is not full;
// the square root and divider are fully pipelined.
// Reset clears all valid bits, the queue and the dimension (to 3).
// When the receiver stalls, a two entry output queue keeps taking results; once it is
// full the whole pipeline holds and the operand ready drops, nothing lost or repeated.
`default_nettype none
`include "vector_arithmetic_unit_assert.svh"
module vector_arithmetic_unit
    import vau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    vau_in_if.sink             operand,
    vau_out_if.source          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [DIM_W-1:0] dim_cfg;
    logic [DIM_W-1:0] dim_eff;
    logic             en;

    vau_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dim     (dim_cfg)
    );

    assign dim_eff = (dim_cfg < DIM_MIN) ? DIM_MIN : ((dim_cfg > DIM_MAX) ? DIM_MAX : dim_cfg);

    // ---------------- stage a: capture
    logic             a_valid_reg;
    op_t              a_op_reg;
    logic [DIM_W-1:0] a_dim_reg;
    word_t            a_l_reg [MAX_DIM];
    word_t            a_r_reg [MAX_DIM];
    word_t            a_sf_reg;

    assign operand.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= operand.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg   <= op_t'(operand.operation);
            a_dim_reg  <= dim_eff;
            a_l_reg[0] <= operand.left_x;
            a_l_reg[1] <= operand.left_y;
            a_l_reg[2] <= operand.left_z;
            a_l_reg[3] <= operand.left_w;
            a_r_reg[0] <= operand.right_x;
            a_r_reg[1] <= operand.right_y;
            a_r_reg[2] <= operand.right_z;
            a_r_reg[3] <= operand.right_w;
            a_sf_reg   <= operand.scale_factor;
        end
    end

    // ---------------- stage b: products, squares, add/sub/negate
    logic             b_valid_reg;
    op_t              b_op_reg;
    logic [DIM_W-1:0] b_dim_reg;
    lin_t             b_lin_reg  [MAX_DIM];
    prod_t            b_prod_reg [MAX_DIM];
    logic [PROD_W-1:0] b_lsq_reg [MAX_DIM];
    logic [PROD_W-1:0] b_rsq_reg [MAX_DIM];
    mag_t             b_lmag_reg [MAX_DIM];
    mag_t             b_rmag_reg [MAX_DIM];
    logic [MAX_DIM-1:0] b_lneg_reg;
    logic [MAX_DIM-1:0] b_rneg_reg;

    lin_t              b_lin_next  [MAX_DIM];
    prod_t             b_prod_next [MAX_DIM];
    logic [PROD_W-1:0] b_lsq_next  [MAX_DIM];
    logic [PROD_W-1:0] b_rsq_next  [MAX_DIM];
    mag_t              b_lmag_next [MAX_DIM];
    mag_t              b_rmag_next [MAX_DIM];

    always_comb
    begin
        word_t mul_b;
        logic  on;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            on    = DIM_W'(i) < a_dim_reg;
            mul_b = (a_op_reg == OP_SCALE) ? a_sf_reg : a_r_reg[i];
            b_lmag_next[i] = a_l_reg[i][DATA_W-1] ? mag_t'(-a_l_reg[i]) : mag_t'(a_l_reg[i]);
            b_rmag_next[i] = a_r_reg[i][DATA_W-1] ? mag_t'(-a_r_reg[i]) : mag_t'(a_r_reg[i]);
            case (a_op_reg)
                OP_ADD:  b_lin_next[i] = lin_t'(a_l_reg[i]) + lin_t'(a_r_reg[i]);
                OP_SUB:  b_lin_next[i] = lin_t'(a_l_reg[i]) - lin_t'(a_r_reg[i]);
                OP_NEG:  b_lin_next[i] = -lin_t'(a_l_reg[i]);
                default: b_lin_next[i] = '0;
            endcase
            b_prod_next[i] = a_l_reg[i] * mul_b;
            b_lsq_next[i]  = PROD_W'(b_lmag_next[i]) * PROD_W'(b_lmag_next[i]);
            b_rsq_next[i]  = PROD_W'(b_rmag_next[i]) * PROD_W'(b_rmag_next[i]);
            if (!on)
            begin
                b_lin_next[i]  = '0;
                b_prod_next[i] = '0;
                b_lsq_next[i]  = '0;
                b_rsq_next[i]  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_op_reg  <= a_op_reg;
            b_dim_reg <= a_dim_reg;
            for (int i = 0; i < MAX_DIM; i++)
            begin
                b_lin_reg[i]  <= b_lin_next[i];
                b_prod_reg[i] <= b_prod_next[i];
                b_lsq_reg[i]  <= b_lsq_next[i];
                b_rsq_reg[i]  <= b_rsq_next[i];
                b_lmag_reg[i] <= b_lmag_next[i];
                b_rmag_reg[i] <= b_rmag_next[i];
                b_lneg_reg[i] <= a_l_reg[i][DATA_W-1];
                b_rneg_reg[i] <= a_r_reg[i][DATA_W-1];
            end
        end
    end

    // ---------------- stage c: sums, rounding, saturation
    logic                   c_valid_reg;
    sq_side_t               c_side_reg;
    logic [1:0][PROD_W-1:0] c_rad_reg;
    sq_side_t               c_side_next;
    logic [1:0][PROD_W-1:0] c_rad_next;

    always_comb
    begin
        logic signed [WIDE_W-1:0] dot_sum;
        logic signed [WIDE_W-1:0] scl;
        logic [SUM_W-1:0]         lsum;
        logic [SUM_W-1:0]         rsum;
        logic [DATA_W:0]          sw;
        dot_sum = ROUND_HALF;
        scl     = '0;
        lsum    = '0;
        rsum    = '0;
        c_side_next       = '0;
        c_side_next.op    = b_op_reg;
        c_side_next.dim   = b_dim_reg;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            dot_sum = dot_sum + WIDE_W'(b_prod_reg[i]);
            lsum    = lsum + SUM_W'(b_lsq_reg[i]);
            rsum    = rsum + SUM_W'(b_rsq_reg[i]);
            c_side_next.lmag[i] = b_lmag_reg[i];
            c_side_next.rmag[i] = b_rmag_reg[i];
            case (b_op_reg) inside
                OP_ADD, OP_SUB, OP_NEG:
                begin
                    sw = sat_word(WIDE_W'(b_lin_reg[i]));
                end
                OP_SCALE:
                begin
                    scl = (WIDE_W'(b_prod_reg[i]) + ROUND_HALF) >>> FRAC_BITS;
                    sw  = sat_word(scl);
                end
                default:
                begin
                    sw = '0;
                end
            endcase
            c_side_next.vec[i] = sw[DATA_W-1:0];
            c_side_next.sat    = c_side_next.sat | sw[DATA_W];
        end
        c_side_next.lneg = b_lneg_reg;
        c_side_next.rneg = b_rneg_reg;
        if (b_op_reg == OP_DOT)
        begin
            sw = sat_word(dot_sum >>> FRAC_BITS);
            c_side_next.scal = sw[DATA_W-1:0];
            c_side_next.sat  = sw[DATA_W];
        end
        // a sum of squares past 64 bits stands for a length of 2^32
        c_side_next.lovf = |lsum[SUM_W-1:PROD_W];
        c_side_next.rovf = |rsum[SUM_W-1:PROD_W];
        c_rad_next[0] = c_side_next.lovf ? '0 : lsum[PROD_W-1:0];
        c_rad_next[1] = c_side_next.rovf ? '0 : rsum[PROD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= c_side_next;
            c_rad_reg  <= c_rad_next;
        end
    end

    // ---------------- square root
    logic                   s_valid;
    logic [1:0][DATA_W-1:0] s_root;
    logic [1:0]             s_up;
    sq_side_t               s_side;

    vau_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_rad    (c_rad_reg),
        .in_side   (c_side_reg),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_up    (s_up),
        .out_side  (s_side)
    );

    // ---------------- stage r: length rounding, magnitude, divider operands
    logic                        r_valid_reg;
    div_side_t                   r_side_reg;
    logic [LANES-1:0][NUM_W-1:0] r_num_reg;
    logic [LANES-1:0][LEN_W-1:0] r_den_reg;
    div_side_t                   r_side_next;
    logic [LANES-1:0][NUM_W-1:0] r_num_next;
    logic [LANES-1:0][LEN_W-1:0] r_den_next;

    always_comb
    begin
        logic [LEN_W-1:0] ml;
        logic [LEN_W-1:0] mr;
        ml = s_side.lovf ? (LEN_W'(1) << DATA_W) : (LEN_W'(s_root[0]) + LEN_W'(s_up[0]));
        mr = s_side.rovf ? (LEN_W'(1) << DATA_W) : (LEN_W'(s_root[1]) + LEN_W'(s_up[1]));
        r_side_next.op    = s_side.op;
        r_side_next.dim   = s_side.dim;
        r_side_next.vec   = s_side.vec;
        r_side_next.scal  = s_side.scal;
        r_side_next.sat   = s_side.sat;
        r_side_next.lneg  = s_side.lneg;
        r_side_next.rneg  = s_side.rneg;
        r_side_next.lzero = (ml == '0);
        r_side_next.rzero = (mr == '0);
        if (s_side.op == OP_MAG)
        begin
            if (|ml[LEN_W-1:DATA_W-1])
            begin
                r_side_next.scal = SAT_HI[DATA_W-1:0];
                r_side_next.sat  = 1'b1;
            end
            else
            begin
                r_side_next.scal = ml[DATA_W-1:0];
            end
        end
        for (int i = 0; i < MAX_DIM; i++)
        begin
            r_num_next[i]         = (NUM_W'(s_side.lmag[i]) << FRAC_BITS) + NUM_W'(ml >> 1);
            r_den_next[i]         = ml;
            r_num_next[MAX_DIM+i] = (NUM_W'(s_side.rmag[i]) << FRAC_BITS) + NUM_W'(mr >> 1);
            r_den_next[MAX_DIM+i] = mr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_valid_reg <= 1'b0;
        else if (en)
            r_valid_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_side_reg <= r_side_next;
            r_num_reg  <= r_num_next;
            r_den_reg  <= r_den_next;
        end
    end

    // ---------------- divider
    logic                        d_valid;
    logic [LANES-1:0][QUO_W-1:0] d_quo;
    div_side_t                   d_side;

    vau_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid_reg),
        .in_num    (r_num_reg),
        .in_den    (r_den_reg),
        .in_side   (r_side_reg),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    // ---------------- stage p: signed normalized elements and their products
    logic      p_valid_reg;
    div_side_t p_side_reg;
    nprod_t    p_prod_reg [MAX_DIM];
    div_side_t p_side_next;
    nprod_t    p_prod_next [MAX_DIM];

    always_comb
    begin
        nrm_t nl;
        nrm_t nr;
        p_side_next = d_side;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            nl = d_side.lneg[i] ? -nrm_t'(d_quo[i]) : nrm_t'(d_quo[i]);
            nr = d_side.rneg[i] ? -nrm_t'(d_quo[MAX_DIM+i]) : nrm_t'(d_quo[MAX_DIM+i]);
            if (DIM_W'(i) >= d_side.dim)
            begin
                nl = '0;
                nr = '0;
            end
            if (d_side.op == OP_NORM)
                p_side_next.vec[i] = DATA_W'(nl);
            p_prod_next[i] = nl * nr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_side_reg <= p_side_next;
            for (int i = 0; i < MAX_DIM; i++)
                p_prod_reg[i] <= p_prod_next[i];
        end
    end

    // ---------------- final result: cosine sum, zero length, status
    res_t fin;

    always_comb
    begin
        logic signed [WIDE_W-1:0] cos_sum;
        logic [DATA_W:0]          sw;
        logic                     sat;
        logic                     zero;
        cos_sum = ROUND_HALF;
        for (int i = 0; i < MAX_DIM; i++)
            cos_sum = cos_sum + WIDE_W'(p_prod_reg[i]);
        sw       = sat_word(cos_sum >>> FRAC_BITS);
        fin.vec  = p_side_reg.vec;
        fin.scal = p_side_reg.scal;
        sat      = p_side_reg.sat;
        if (p_side_reg.op == OP_COS)
        begin
            fin.scal = sw[DATA_W-1:0];
            sat      = sat | sw[DATA_W];
        end
        zero = ((p_side_reg.op == OP_NORM) && p_side_reg.lzero) ||
               ((p_side_reg.op == OP_COS) && (p_side_reg.lzero || p_side_reg.rzero));
        if (zero)
        begin
            fin.vec    = '0;
            fin.scal   = '0;
            fin.status = ST_ZERO;
        end
        else
        begin
            fin.status = sat ? ST_SAT : ST_OK;
        end
    end

    // ---------------- output queue
    res_t       fifo_mem_reg [FIFO_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;
    res_t       head;

    // the pipeline holds only while the queue is full
    assign en   = (cnt_reg != 2'(FIFO_DEPTH));
    assign push = en && p_valid_reg;
    assign pop  = result.valid && result.ready;
    assign head = fifo_mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem_reg[wr_ptr_reg] <= fin;
    end

    assign result.valid      = (cnt_reg != '0);
    assign result.out_x      = head.vec[0];
    assign result.out_y      = head.vec[1];
    assign result.out_z      = head.vec[2];
    assign result.out_w      = head.vec[3];
    assign result.scalar_out = head.scal;
    assign result.status     = head.status;

    // ---------------- assertions
    `VAU_ASSERT_IMP(a_zero_clears, clk, rst_n, result.valid && result.status == ST_ZERO, result.scalar_out == '0 && result.out_x == '0 && result.out_y == '0)
    `VAU_ASSERT_IMP(a_lanes_off, clk, rst_n, result.valid && dim_eff == DIM_MIN, result.out_z == '0 && result.out_w == '0)
    `VAU_ASSERT_NXT(a_accept_enters, clk, rst_n, operand.valid && operand.ready, a_valid_reg)

endmodule
`default_nettype wire

FILE: rtl/vau_apb_regs.sv
// apb configuration register block: holds the vector dimension
// depends on vau_pkg
`default_nettype none
module vau_apb_regs
    import vau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [DIM_W-1:0]   dim
);

    logic [DIM_W-1:0] dim_reg;
    logic [DIM_W-1:0] dim_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign dim    = dim_reg;

    always_comb
    begin
        dim_next = dim_reg;
        if (wr_en)
        begin
            unique case (paddr[PADDR_W-1:2])
                REG_DIM: dim_next = pwdata[DIM_W-1:0];
                default: dim_next = dim_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[PADDR_W-1:2])
            REG_DIM: prdata = PDATA_W'(dim_reg);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dim_reg <= DIM_RESET;
        else
            dim_reg <= dim_next;
    end

endmodule
`default_nettype wire

FILE: rtl/vau_sqrt_pipe.sv
// pipelined integer square root, two lanes, one result bit per stage
// depends on vau_pkg
`default_nettype none
module vau_sqrt_pipe
    import vau_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [1:0][PROD_W-1:0]       in_rad,
    input  sq_side_t                     in_side,
    output logic                         out_valid,
    output logic [1:0][DATA_W-1:0]       out_root,
    output logic [1:0]                   out_up,
    output sq_side_t                     out_side
);

    logic [1:0][PROD_W-1:0] rem_reg  [1:SQ_STEPS];
    logic [1:0][PROD_W-1:0] res_reg  [1:SQ_STEPS];
    sq_side_t               side_reg [1:SQ_STEPS];
    logic [SQ_STEPS:1]      vld_reg;

    genvar k;
    for (k = 1; k <= SQ_STEPS; k++)
    begin : g_step
        localparam logic [PROD_W-1:0] BIT_K = PROD_W'(1) << (PROD_W - 2 * k);
        logic [1:0][PROD_W-1:0] rem_prev;
        logic [1:0][PROD_W-1:0] res_prev;
        logic [1:0][PROD_W-1:0] rem_next;
        logic [1:0][PROD_W-1:0] res_next;
        logic                   vld_prev;
        sq_side_t               side_prev;

        if (k == 1)
        begin : g_first
            assign rem_prev  = in_rad;
            assign res_prev  = '0;
            assign vld_prev  = in_valid;
            assign side_prev = in_side;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign res_prev  = res_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb
        begin
            for (int j = 0; j < 2; j++)
            begin
                if (rem_prev[j] >= res_prev[j] + BIT_K)
                begin
                    rem_next[j] = rem_prev[j] - (res_prev[j] + BIT_K);
                    res_next[j] = (res_prev[j] >> 1) + BIT_K;
                end
                else
                begin
                    rem_next[j] = rem_prev[j];
                    res_next[j] = res_prev[j] >> 1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[SQ_STEPS];
    assign out_side  = side_reg[SQ_STEPS];

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            out_root[j] = res_reg[SQ_STEPS][j][DATA_W-1:0];
            // remainder above the root: the nearest integer is one higher
            out_up[j]   = rem_reg[SQ_STEPS][j] > res_reg[SQ_STEPS][j];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/vau_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage over all lanes
// depends on vau_pkg
`default_nettype none
module vau_div_pipe
    import vau_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]   in_num,
    input  logic [LANES-1:0][LEN_W-1:0]   in_den,
    input  div_side_t                     in_side,
    output logic                          out_valid,
    output logic [LANES-1:0][QUO_W-1:0]   out_quo,
    output div_side_t                     out_side
);

    localparam int CMP_W = LEN_W + QUO_W;

    logic [LANES-1:0][NUM_W-1:0] rem_reg  [1:QUO_W];
    logic [LANES-1:0][LEN_W-1:0] den_reg  [1:QUO_W];
    logic [LANES-1:0][QUO_W-1:0] quo_reg  [1:QUO_W];
    div_side_t                   side_reg [1:QUO_W];
    logic [QUO_W:1]              vld_reg;

    genvar k;
    for (k = 1; k <= QUO_W; k++)
    begin : g_step
        localparam int SHIFT = QUO_W - k;
        logic [LANES-1:0][NUM_W-1:0] rem_prev;
        logic [LANES-1:0][LEN_W-1:0] den_prev;
        logic [LANES-1:0][QUO_W-1:0] quo_prev;
        logic [LANES-1:0][NUM_W-1:0] rem_next;
        logic [LANES-1:0][QUO_W-1:0] quo_next;
        logic                        vld_prev;
        div_side_t                   side_prev;

        if (k == 1)
        begin : g_first
            assign rem_prev  = in_num;
            assign den_prev  = in_den;
            assign quo_prev  = '0;
            assign vld_prev  = in_valid;
            assign side_prev = in_side;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign vld_prev  = vld_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb
        begin
            logic [CMP_W-1:0] shifted;
            for (int j = 0; j < LANES; j++)
            begin
                shifted = CMP_W'(den_prev[j]) << SHIFT;
                if (CMP_W'(rem_prev[j]) >= shifted)
                begin
                    rem_next[j] = rem_prev[j] - shifted[NUM_W-1:0];
                    quo_next[j] = {quo_prev[j][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j] = rem_prev[j];
                    quo_next[j] = {quo_prev[j][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_prev;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign out_quo   = quo_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule
`default_nettype wire

FILE: tb/tb_vector_arithmetic_unit.sv
// testbench of the vector arithmetic unit: random and directed items checked against
// a bit-exact predictor, with the dimension register swept over APB
// depends on vau_pkg, vau_in_if, vau_out_if and vector_arithmetic_unit
`timescale 1ns / 100ps
module tb_vector_arithmetic_unit;
    import vau_pkg::*;

    typedef struct {
        op_t   op;
        vec_t  lhs;
        vec_t  rhs;
        word_t factor;
    } vec_item_t;

    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 3000;
    localparam int SQUEEZE_LEN  = 300;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    vau_in_if  op_ch ();
    vau_out_if res_ch ();

    vector_arithmetic_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (op_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    vec_item_t   pending_q[$];
    res_t        expected_q[$];
    logic [2:0]  dim_reg;
    logic        took;
    logic        no_idle;
    int          squeeze_req;
    int          errors;
    int          stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic logic [32:0] clamp32(input logic signed [69:0] v);
        if (v > 70'sd2147483647)
            return {1'b1, 32'h7fff_ffff};
        if (v < -70'sd2147483648)
            return {1'b1, 32'h8000_0000};
        return {1'b0, v[31:0]};
    endfunction

    // exact sum of products, rounded to nearest with ties up, then clamped
    function automatic logic [32:0] round_prod_sum(input vec_t a, input vec_t b, input int n);
        logic signed [69:0] acc;
        acc = 70'sd32768;
        for (int i = 0; i < n; i++)
            acc += 70'(signed'(a[i])) * 70'(signed'(b[i]));
        return clamp32(acc >>> FRAC_BITS);
    endfunction

    function automatic logic [65:0] abs66(input word_t w);
        logic signed [65:0] t;
        t = 66'(signed'(w));
        return (t < 0) ? 66'(-t) : 66'(t);
    endfunction

    function automatic logic [32:0] vec_length(input vec_t a, input int n);
        logic [65:0] s;
        logic [65:0] m;
        logic [65:0] root;
        logic [65:0] probe;
        s = '0;
        for (int i = 0; i < n; i++)
        begin
            m = abs66(a[i]);
            s += m * m;
        end
        if (s > 66'h0_ffff_ffff_ffff_ffff)
            return 33'h1_0000_0000;
        root = '0;
        probe = 66'd1 << 62;
        while (probe > s)
            probe >>= 2;
        while (probe != 0)
        begin
            if (s >= root + probe)
            begin
                s -= root + probe;
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        // s now holds the remainder
        if (s > root)
            root++;
        return root[32:0];
    endfunction

    function automatic logic unit_vector(input vec_t a, input int n,
                                         output vec_t u, inout logic sat);
        logic [32:0] m;
        logic [65:0] q;
        logic signed [69:0] v;
        logic [32:0] c;
        u = '0;
        m = vec_length(a, n);
        if (m == 0)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            q = ((abs66(a[i]) << FRAC_BITS) + 66'(m / 2)) / 66'(m);
            v = a[i][31] ? -70'(q) : 70'(q);
            c = clamp32(v);
            sat |= c[32];
            u[i] = c[31:0];
        end
        return 1'b1;
    endfunction

    function automatic res_t predict_result(input vec_item_t it, input logic [2:0] dim);
        res_t r;
        int n;
        logic sat;
        logic zero;
        logic [32:0] c;
        vec_t nl;
        vec_t nr;
        n = (dim < 2) ? 2 : ((dim > 4) ? 4 : int'(dim));
        r.vec = '0;
        r.scal = '0;
        sat = 1'b0;
        zero = 1'b0;
        case (it.op)
            OP_ADD, OP_SUB, OP_NEG:
                for (int i = 0; i < n; i++)
                begin
                    if (it.op == OP_ADD)
                        c = clamp32(70'(signed'(it.lhs[i])) + 70'(signed'(it.rhs[i])));
                    else if (it.op == OP_SUB)
                        c = clamp32(70'(signed'(it.lhs[i])) - 70'(signed'(it.rhs[i])));
                    else
                        c = clamp32(-70'(signed'(it.lhs[i])));
                    sat |= c[32];
                    r.vec[i] = c[31:0];
                end
            OP_SCALE:
                for (int i = 0; i < n; i++)
                begin
                    c = round_prod_sum(vec_t'(it.lhs[i]), vec_t'(it.factor), 1);
                    sat |= c[32];
                    r.vec[i] = c[31:0];
                end
            OP_DOT:
            begin
                c = round_prod_sum(it.lhs, it.rhs, n);
                sat = c[32];
                r.scal = c[31:0];
            end
            OP_MAG:
            begin
                c = clamp32(70'(vec_length(it.lhs, n)));
                sat = c[32];
                r.scal = c[31:0];
            end
            OP_NORM:
            begin
                if (!unit_vector(it.lhs, n, nl, sat))
                    zero = 1'b1;
                r.vec = nl;
            end
            default:
            begin
                if (!unit_vector(it.lhs, n, nl, sat) || !unit_vector(it.rhs, n, nr, sat))
                    zero = 1'b1;
                else
                begin
                    c = round_prod_sum(nl, nr, n);
                    sat |= c[32];
                    r.scal = c[31:0];
                end
            end
        endcase
        if (zero)
        begin
            r.vec = '0;
            r.scal = '0;
            r.status = ST_ZERO;
        end
        else
            r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic word_t rand_word();
        case ($urandom_range(0, 6))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return word_t'($urandom_range(0, 1 << 18)) * ($urandom_range(0, 1) ? 1 : -1);
            4: return word_t'($urandom_range(0, 1 << 24)) * ($urandom_range(0, 1) ? 1 : -1);
            default: return $urandom;
        endcase
    endfunction

    function automatic vec_item_t rand_item();
        vec_item_t it;
        it.op = op_t'($urandom_range(0, 7));
        for (int i = 0; i < MAX_DIM; i++)
        begin
            it.lhs[i] = rand_word();
            it.rhs[i] = rand_word();
        end
        it.factor = rand_word();
        if ($urandom_range(0, 9) == 0)
            it.lhs = '0;
        if ($urandom_range(0, 9) == 0)
            it.rhs = '0;
        return it;
    endfunction

    function automatic vec_item_t make_item(input op_t op, input word_t l, input word_t r,
                                            input word_t f);
        vec_item_t it;
        it.op = op;
        it.lhs = {4{l}};
        it.rhs = {4{r}};
        it.factor = f;
        return it;
    endfunction

    task automatic apb_write(input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {REG_DIM, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        dim_reg = value[2:0];
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !op_ch.valid && expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------- operand driver ----------------
    always @(negedge clk)
    begin
        int gap;
        vec_item_t it;
        if (rst_n && !(op_ch.valid && !took))
        begin
            if (gap > 0)
            begin
                gap--;
                op_ch.valid <= 1'b0;
            end
            else if (pending_q.size() != 0 && !no_idle && $urandom_range(0, 15) == 0)
            begin
                gap = $urandom_range(0, 6);
                op_ch.valid <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                it = pending_q.pop_front();
                op_ch.valid <= 1'b1;
                op_ch.operation <= it.op;
                op_ch.left_x <= it.lhs[0];
                op_ch.left_y <= it.lhs[1];
                op_ch.left_z <= it.lhs[2];
                op_ch.left_w <= it.lhs[3];
                op_ch.right_x <= it.rhs[0];
                op_ch.right_y <= it.rhs[1];
                op_ch.right_z <= it.rhs[2];
                op_ch.right_w <= it.rhs[3];
                op_ch.scale_factor <= it.factor;
            end
            else
                op_ch.valid <= 1'b0;
        end
    end

    // ---------------- result receiver ----------------
    always @(negedge clk)
    begin
        int hold;
        int squeeze_seen;
        if (rst_n)
        begin
            if (squeeze_seen != squeeze_req)
            begin
                squeeze_seen = squeeze_req;
                hold = SQUEEZE_LEN;
            end
            if (hold > 0)
            begin
                hold--;
                res_ch.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 15) == 0)
            begin
                hold = $urandom_range(0, 6);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        vec_item_t it;
        res_t e;
        logic moved;
        logic accepted;
        moved = 1'b0;
        accepted = 1'b0;
        if (rst_n && op_ch.valid && op_ch.ready)
        begin
            it.op = op_t'(op_ch.operation);
            it.lhs = {op_ch.left_w, op_ch.left_z, op_ch.left_y, op_ch.left_x};
            it.rhs = {op_ch.right_w, op_ch.right_z, op_ch.right_y, op_ch.right_x};
            it.factor = op_ch.scale_factor;
            expected_q.push_back(predict_result(it, dim_reg));
            accepted = 1'b1;
            moved = 1'b1;
        end
        took <= accepted;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            moved = 1'b1;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (res_ch.out_x !== e.vec[0])
                begin
                    $error("out_x expected %h actual %h", e.vec[0], res_ch.out_x);
                    errors++;
                end
                if (res_ch.out_y !== e.vec[1])
                begin
                    $error("out_y expected %h actual %h", e.vec[1], res_ch.out_y);
                    errors++;
                end
                if (res_ch.out_z !== e.vec[2])
                begin
                    $error("out_z expected %h actual %h", e.vec[2], res_ch.out_z);
                    errors++;
                end
                if (res_ch.out_w !== e.vec[3])
                begin
                    $error("out_w expected %h actual %h", e.vec[3], res_ch.out_w);
                    errors++;
                end
                if (res_ch.scalar_out !== e.scal)
                begin
                    $error("scalar_out expected %h actual %h", e.scal, res_ch.scalar_out);
                    errors++;
                end
                if (res_ch.status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, res_ch.status);
                    errors++;
                end
            end
        end
        if (moved || (pending_q.size() == 0 && expected_q.size() == 0 && !op_ch.valid))
            stall_cycles = 0;
        else if (++stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- test sequence ----------------
    initial
    begin
        logic [2:0] dims[7];
        dims = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd1, 3'd5, 3'd3};
        errors = 0;
        stall_cycles = 0;
        squeeze_req = 0;
        no_idle = 1'b0;
        dim_reg = DIM_RESET;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        op_ch.valid = 1'b0;
        op_ch.operation = '0;
        op_ch.left_x = '0;
        op_ch.left_y = '0;
        op_ch.left_z = '0;
        op_ch.left_w = '0;
        op_ch.right_x = '0;
        op_ch.right_y = '0;
        op_ch.right_z = '0;
        op_ch.right_w = '0;
        op_ch.scale_factor = '0;
        res_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset dimension
        pending_q.push_back(make_item(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 0));
        pending_q.push_back(make_item(OP_ADD, 32'h8000_0000, 32'h8000_0000, 0));
        pending_q.push_back(make_item(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 0));
        pending_q.push_back(make_item(OP_SUB, 32'h0001_0000, 32'h0000_8000, 0));
        pending_q.push_back(make_item(OP_NEG, 32'h8000_0000, 0, 0));
        pending_q.push_back(make_item(OP_NEG, 32'h7fff_ffff, 0, 0));
        pending_q.push_back(make_item(OP_SCALE, 32'h7fff_ffff, 0, 32'h7fff_ffff));
        pending_q.push_back(make_item(OP_SCALE, 32'h0000_0001, 0, 32'h0000_8000));
        pending_q.push_back(make_item(OP_SCALE, 32'hffff_ffff, 0, 32'h0000_8000));
        pending_q.push_back(make_item(OP_SCALE, 32'h0003_0000, 0, 32'hffff_0000));
        pending_q.push_back(make_item(OP_DOT, 32'h8000_0000, 32'h8000_0000, 0));
        pending_q.push_back(make_item(OP_DOT, 32'h0002_0000, 32'hfffd_0000, 0));
        pending_q.push_back(make_item(OP_MAG, 32'h8000_0000, 0, 0));
        pending_q.push_back(make_item(OP_MAG, 32'h0003_0000, 0, 0));
        pending_q.push_back(make_item(OP_MAG, 0, 0, 0));
        pending_q.push_back(make_item(OP_NORM, 0, 0, 0));
        pending_q.push_back(make_item(OP_NORM, 32'h0000_0001, 0, 0));
        pending_q.push_back(make_item(OP_NORM, 32'hfff0_0000, 0, 0));
        pending_q.push_back(make_item(OP_COS, 32'h0001_0000, 0, 0));
        pending_q.push_back(make_item(OP_COS, 0, 32'h0001_0000, 0));
        pending_q.push_back(make_item(OP_COS, 32'h7fff_ffff, 32'h8000_0000, 0));
        pending_q.push_back(make_item(OP_COS, 32'h0000_0003, 32'h0005_0000, 0));
        drain();

        for (int p = 0; p < 7; p++)
        begin
            apb_write({29'd0, dims[p]});
            no_idle = (p == 6);
            for (int k = 0; k < 255; k++)
                pending_q.push_back(rand_item());
            if (p == 1)
                squeeze_req++;
            drain();
        end

        if (errors == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
